// ----- rtl/core/sbmq_pkg.sv -----
package sbmq_pkg;

	localparam int DEPTH_DEF = 16;

	localparam int CAP_W  = 5;
	localparam int ACT_W  = 3;
	localparam int WORD_W = 32;
	localparam int POS_W  = 4;
	localparam int SLOT_W = 4;
	localparam int FILL_W = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd1;
	localparam logic [ACT_W-1:0] ACT_FIND   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_READ   = 3'd4;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [ACT_W-1:0]  action_t;

endpackage

// ----- rtl/core/sbmq_if.sv -----
interface sbmq_req_if;
	logic                          valid;
	logic                          ready;
	sbmq_pkg::action_t             action;
	sbmq_pkg::word_t               ident;
	sbmq_pkg::word_t               payload;
	logic [sbmq_pkg::POS_W-1:0]    position;

	modport source (output valid, action, ident, payload, position, input ready);
	modport sink   (input valid, action, ident, payload, position, output ready);
endinterface

interface sbmq_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [sbmq_pkg::SLOT_W-1:0]   slot;
	logic                          ok;
	logic                          dropped;
	sbmq_pkg::word_t               entry_ident;
	sbmq_pkg::word_t               entry_payload;
	logic [sbmq_pkg::FILL_W-1:0]   fill;

	modport source (output valid, slot, ok, dropped, entry_ident, entry_payload, fill,
		input ready);
	modport sink   (input valid, slot, ok, dropped, entry_ident, entry_payload, fill,
		output ready);
endinterface

// ----- rtl/core/sorted_bounded_message_queue_unit.sv -----
// Channel   Dir  Handshake       Contents
// req       in   valid/ready     action, ident, payload, position
// rsp       out  valid/ready     slot, ok, dropped, entry_ident, entry_payload, fill
// cfg       in   cfg_we only     cfg_wdata = capacity
//
// One request at a time; the key/data RAM (one write, one registered read port) is
// walked one entry per cycle. Insert shifts larger keys up a slot from the tail, then
// writes the new entry; remove shifts entries above position down; find compares from
// slot 0 to a match or the fill; read fetches one entry; all then load the output register.
// arst_n clears the count, capacity (to 16, clamped to DEPTH) and handshake state.
// req is taken again once the result sits in the output register; rsp stalls hold it there.
module sorted_bounded_message_queue_unit #(
	parameter int DEPTH = sbmq_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [sbmq_pkg::CAP_W-1:0]  cfg_wdata,
	sbmq_req_if.sink                    req,
	sbmq_rsp_if.source                  rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > sbmq_pkg::CAP_W) ? CW : sbmq_pkg::CAP_W;
	localparam int CAP_INIT_I = (DEPTH < int'(sbmq_pkg::CAP_RESET)) ? DEPTH
		: int'(sbmq_pkg::CAP_RESET);
	localparam logic [CW-1:0] CAP_INIT = CW'(CAP_INIT_I);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_INS  = 7'b0000010,
		S_PUT  = 7'b0000100,
		S_REM  = 7'b0001000,
		S_FIND = 7'b0010000,
		S_RDO  = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] cap_q, cap_d;
	logic [CW-1:0] idx_q, idx_d;
	sbmq_pkg::word_t ident_q, payload_q;

	logic [sbmq_pkg::SLOT_W-1:0] res_slot_q, res_slot_d;
	logic res_ok_q, res_ok_d, res_drop_q, res_drop_d;
	sbmq_pkg::word_t res_eid_q, res_eid_d, res_epl_q, res_epl_d;

	logic out_valid_q, out_load;
	logic [sbmq_pkg::SLOT_W-1:0] out_slot_q;
	logic out_ok_q, out_drop_q;
	sbmq_pkg::word_t out_eid_q, out_epl_q;
	logic [sbmq_pkg::FILL_W-1:0] out_fill_q;

	// key/data RAM
	sbmq_pkg::word_t key_mem [DEPTH];
	sbmq_pkg::word_t data_mem [DEPTH];
	logic mem_we, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	sbmq_pkg::word_t wr_key, wr_data, rd_key_q, rd_data_q;

	logic [XW-1:0] cap_ext;
	logic [CW-1:0] cap_new;
	logic          full;
	logic [CW-1:0] ins_n;
	logic          pos_ok;
	logic [CW-1:0] pos_c;
	logic          req_acc;

	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;

	// capacity clamped to [1, DEPTH]
	always_comb begin
		cap_ext = XW'(cfg_wdata);
		if (cap_ext == '0) begin
			cap_new = CW'(1);
		end else if (cap_ext > XW'(DEPTH)) begin
			cap_new = CW'(DEPTH);
		end else begin
			cap_new = CW'(cap_ext);
		end
	end

	assign full   = (count_q >= cap_q);
	assign ins_n  = full ? (cap_q - CW'(1)) : count_q;
	assign pos_ok = (XW'(req.position) < XW'(count_q));
	assign pos_c  = CW'(req.position);

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		cap_d      = cap_q;
		idx_d      = idx_q;
		res_slot_d = res_slot_q;
		res_ok_d   = res_ok_q;
		res_drop_d = res_drop_q;
		res_eid_d  = res_eid_q;
		res_epl_d  = res_epl_q;
		mem_we     = 1'b0;
		wr_addr    = AW'(idx_q);
		wr_key     = rd_key_q;
		wr_data    = rd_data_q;
		rd_en      = 1'b0;
		rd_addr    = '0;
		out_load   = 1'b0;

		if (cfg_we) begin
			cap_d = cap_new;
			if (count_q > cap_new) begin
				count_d = cap_new;
			end
		end

		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					res_slot_d = '0;
					res_ok_d   = 1'b0;
					res_drop_d = 1'b0;
					res_eid_d  = '0;
					res_epl_d  = '0;
					state_d    = S_DONE;
					unique case (req.action)
						sbmq_pkg::ACT_INSERT: begin
							res_drop_d = full;
							idx_d      = ins_n;
							count_d    = ins_n + CW'(1);
							if (ins_n == '0) begin
								state_d = S_PUT;
							end else begin
								rd_en   = 1'b1;
								rd_addr = AW'(ins_n - CW'(1));
								state_d = S_INS;
							end
						end
						sbmq_pkg::ACT_REMOVE: begin
							if (pos_ok) begin
								idx_d      = pos_c;
								res_slot_d = req.position;
								res_ok_d   = 1'b1;
								if ((pos_c + CW'(1)) < count_q) begin
									rd_en   = 1'b1;
									rd_addr = AW'(pos_c + CW'(1));
									state_d = S_REM;
								end else begin
									count_d = count_q - CW'(1);
								end
							end
						end
						sbmq_pkg::ACT_FIND: begin
							if (count_q != '0) begin
								idx_d   = '0;
								rd_en   = 1'b1;
								state_d = S_FIND;
							end
						end
						sbmq_pkg::ACT_CLEAR: begin
							count_d  = '0;
							res_ok_d = 1'b1;
						end
						sbmq_pkg::ACT_READ: begin
							if (pos_ok) begin
								res_slot_d = req.position;
								rd_en      = 1'b1;
								rd_addr    = AW'(pos_c);
								state_d    = S_RDO;
							end
						end
						default: ;
					endcase
				end
			end
			S_INS: begin
				// shift larger key up one, fetch the next one down
				if (rd_key_q > ident_q) begin
					mem_we = 1'b1;
					idx_d  = idx_q - CW'(1);
					if (idx_q == CW'(1)) begin
						state_d = S_PUT;
					end else begin
						rd_en   = 1'b1;
						rd_addr = AW'(idx_q - CW'(2));
					end
				end else begin
					state_d = S_PUT;
				end
			end
			S_PUT: begin
				mem_we     = 1'b1;
				wr_key     = ident_q;
				wr_data    = payload_q;
				res_slot_d = sbmq_pkg::SLOT_W'(idx_q);
				res_ok_d   = 1'b1;
				state_d    = S_DONE;
			end
			S_REM: begin
				mem_we = 1'b1;
				idx_d  = idx_q + CW'(1);
				if ((idx_q + CW'(2)) < count_q) begin
					rd_en   = 1'b1;
					rd_addr = AW'(idx_q + CW'(2));
				end else begin
					count_d = count_q - CW'(1);
					state_d = S_DONE;
				end
			end
			S_FIND: begin
				if (rd_key_q == ident_q) begin
					res_slot_d = sbmq_pkg::SLOT_W'(idx_q);
					res_ok_d   = 1'b1;
					res_eid_d  = rd_key_q;
					res_epl_d  = rd_data_q;
					state_d    = S_DONE;
				end else if ((idx_q + CW'(1)) < count_q) begin
					idx_d   = idx_q + CW'(1);
					rd_en   = 1'b1;
					rd_addr = AW'(idx_q + CW'(1));
				end else begin
					state_d = S_DONE;
				end
			end
			S_RDO: begin
				res_ok_d  = 1'b1;
				res_eid_d = rd_key_q;
				res_epl_d = rd_data_q;
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			cap_q       <= CAP_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			cap_q   <= cap_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q      <= idx_d;
		res_slot_q <= res_slot_d;
		res_ok_q   <= res_ok_d;
		res_drop_q <= res_drop_d;
		res_eid_q  <= res_eid_d;
		res_epl_q  <= res_epl_d;
		if (req_acc) begin
			ident_q   <= req.ident;
			payload_q <= req.payload;
		end
		if (out_load) begin
			out_slot_q <= res_slot_q;
			out_ok_q   <= res_ok_q;
			out_drop_q <= res_drop_q;
			out_eid_q  <= res_eid_q;
			out_epl_q  <= res_epl_q;
			out_fill_q <= sbmq_pkg::FILL_W'(count_q);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[wr_addr]  <= wr_key;
			data_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_key_q  <= key_mem[rd_addr];
			rd_data_q <= data_mem[rd_addr];
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.slot          = out_slot_q;
	assign rsp.ok            = out_ok_q;
	assign rsp.dropped       = out_drop_q;
	assign rsp.entry_ident   = out_eid_q;
	assign rsp.entry_payload = out_epl_q;
	assign rsp.fill          = out_fill_q;

`ifndef SYNTHESIS
	a_count_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cap_q)
		else $error("entry count above capacity");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_we)
		else $error("RAM write while idle");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && (req.action == sbmq_pkg::ACT_CLEAR)) |=> (count_q == '0))
		else $error("clear left entries");

	a_drop_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && res_drop_q) |-> res_ok_q)
		else $error("dropped result without ok");

	a_find_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIND) |-> (idx_q < count_q))
		else $error("find walked past fill");
`endif

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

// codes the block treats as unknown actions
localparam sbmq_pkg::action_t ACT_SPARE_0 = 3'd5;
localparam sbmq_pkg::action_t ACT_SPARE_1 = 3'd6;
localparam sbmq_pkg::action_t ACT_SPARE_2 = 3'd7;

typedef struct packed {
	logic [sbmq_pkg::SLOT_W-1:0] slot;
	logic                        ok;
	logic                        dropped;
	sbmq_pkg::word_t             entry_ident;
	sbmq_pkg::word_t             entry_payload;
	logic [sbmq_pkg::FILL_W-1:0] fill;
} queue_result_t;

class queue_scoreboard;
	sbmq_pkg::word_t              keys[sbmq_pkg::DEPTH_DEF];
	sbmq_pkg::word_t              data[sbmq_pkg::DEPTH_DEF];
	int unsigned                  held;
	logic [sbmq_pkg::CAP_W-1:0]   cap_reg;
	queue_result_t                awaited[$];
	int                           errors;

	function new();
		held = 0;
		cap_reg = sbmq_pkg::CAP_RESET;
		errors = 0;
		foreach (keys[k]) begin
			keys[k] = '0;
			data[k] = '0;
		end
	endfunction

	function int unsigned usable();
		if (cap_reg < 1)
			return 1;
		if (cap_reg > sbmq_pkg::DEPTH_DEF)
			return sbmq_pkg::DEPTH_DEF;
		return 32'(cap_reg);
	endfunction

	function void set_capacity(logic [sbmq_pkg::CAP_W-1:0] value);
		cap_reg = value;
		if (held > usable())
			held = usable();
	endfunction

	function int pending();
		return awaited.size();
	endfunction

	// apply one accepted request to the sorted list and queue its result
	function void note_request(sbmq_pkg::action_t act, sbmq_pkg::word_t id,
		sbmq_pkg::word_t pl, logic [sbmq_pkg::POS_W-1:0] pos);
		queue_result_t r;
		int unsigned   n;
		int unsigned   i;
		r = '0;
		case (act)
			sbmq_pkg::ACT_INSERT: begin
				n = held;
				if (n >= usable()) begin
					n = usable() - 1;
					r.dropped = 1'b1;
				end
				i = n;
				while (i > 0 && keys[i-1] > id) begin
					keys[i] = keys[i-1];
					data[i] = data[i-1];
					i--;
				end
				keys[i] = id;
				data[i] = pl;
				held = n + 1;
				r.slot = i[sbmq_pkg::SLOT_W-1:0];
				r.ok = 1'b1;
			end
			sbmq_pkg::ACT_REMOVE: begin
				if (pos < held) begin
					for (i = 32'(pos); i + 1 < held; i++) begin
						keys[i] = keys[i+1];
						data[i] = data[i+1];
					end
					held--;
					r.slot = pos;
					r.ok = 1'b1;
				end
			end
			sbmq_pkg::ACT_FIND: begin
				for (i = 0; i < held; i++) begin
					if (keys[i] == id) begin
						r.slot = i[sbmq_pkg::SLOT_W-1:0];
						r.ok = 1'b1;
						r.entry_ident = keys[i];
						r.entry_payload = data[i];
						break;
					end
				end
			end
			sbmq_pkg::ACT_CLEAR: begin
				held = 0;
				r.ok = 1'b1;
			end
			sbmq_pkg::ACT_READ: begin
				if (pos < held) begin
					r.slot = pos;
					r.ok = 1'b1;
					r.entry_ident = keys[pos];
					r.entry_payload = data[pos];
				end
			end
			default: ;
		endcase
		r.fill = held[sbmq_pkg::FILL_W-1:0];
		awaited.push_back(r);
	endfunction

	function void compare_field(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			errors++;
		end
	endfunction

	function void check_result(queue_result_t got);
		queue_result_t want;
		if (awaited.size() == 0) begin
			$display("%0t: result with no request outstanding, actual %h", $time, got);
			errors++;
			return;
		end
		want = awaited.pop_front();
		compare_field("slot", 32'(want.slot), 32'(got.slot));
		compare_field("ok", 32'(want.ok), 32'(got.ok));
		compare_field("dropped", 32'(want.dropped), 32'(got.dropped));
		compare_field("entry_ident", want.entry_ident, got.entry_ident);
		compare_field("entry_payload", want.entry_payload, got.entry_payload);
		compare_field("fill", 32'(want.fill), 32'(got.fill));
	endfunction
endclass

module tb_top;
	localparam int STALL_LIMIT = 3000;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [sbmq_pkg::CAP_W-1:0] cfg_wdata;
	bit                         quiet;
	int                         stall_cycles;
	queue_scoreboard            sb;

	sbmq_req_if req_ch();
	sbmq_rsp_if rsp_ch();

	sorted_bounded_message_queue_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: check accepted results, stall ready in short bursts
	initial begin
		int stall_left;
		queue_result_t got;
		stall_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				got.slot = rsp_ch.slot;
				got.ok = rsp_ch.ok;
				got.dropped = rsp_ch.dropped;
				got.entry_ident = rsp_ch.entry_ident;
				got.entry_payload = rsp_ch.entry_payload;
				got.fill = rsp_ch.fill;
				sb.check_result(got);
			end
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left = $urandom_range(0, 4);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
		    (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_request(sbmq_pkg::action_t act, sbmq_pkg::word_t id,
		sbmq_pkg::word_t pl, logic [sbmq_pkg::POS_W-1:0] pos);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.action   <= act;
		req_ch.ident    <= id;
		req_ch.payload  <= pl;
		req_ch.position <= pos;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		sb.note_request(act, id, pl, pos);
	endtask

	task automatic drain();
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// only while idle: no request in flight, all results back
	task automatic write_capacity(logic [sbmq_pkg::CAP_W-1:0] value);
		req_ch.valid <= 1'b0;
		drain();
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_capacity(value);
	endtask

	task automatic random_request();
		int unsigned                roll;
		int unsigned                held;
		sbmq_pkg::action_t          act;
		sbmq_pkg::word_t            id;
		sbmq_pkg::word_t            pl;
		logic [sbmq_pkg::POS_W-1:0] pos;
		held = sb.held;
		roll = $urandom_range(0, 99);
		pl = $urandom();
		if (held > 0 && $urandom_range(0, 3) != 0)
			pos = sbmq_pkg::POS_W'($urandom_range(0, held - 1));
		else
			pos = sbmq_pkg::POS_W'($urandom_range(0, 15));
		case ($urandom_range(0, 5))
			0:       id = $urandom();
			1:       id = $urandom_range(0, 1) ? '1 : '0;
			default: id = $urandom_range(0, 24);
		endcase
		if (roll < 40) begin
			act = sbmq_pkg::ACT_INSERT;
		end else if (roll < 55) begin
			act = sbmq_pkg::ACT_REMOVE;
		end else if (roll < 72) begin
			act = sbmq_pkg::ACT_FIND;
			// mostly look up a key that is held
			if (held > 0 && $urandom_range(0, 3) != 0)
				id = sb.keys[$urandom_range(0, held - 1)];
		end else if (roll < 88) begin
			act = sbmq_pkg::ACT_READ;
		end else if (roll < 90) begin
			act = sbmq_pkg::ACT_CLEAR;
		end else if (roll < 92) begin
			act = ACT_SPARE_0;
		end else if (roll < 94) begin
			act = ACT_SPARE_1;
		end else if (roll < 96) begin
			act = ACT_SPARE_2;
		end else begin
			act = sbmq_pkg::ACT_INSERT;
		end
		send_request(act, id, pl, pos);
	endtask

	initial begin
		logic [sbmq_pkg::CAP_W-1:0] caps[7];
		logic [sbmq_pkg::CAP_W-1:0] cap;
		sb = new();
		quiet = 1'b0;
		stall_cycles = 0;
		caps = '{5'd31, 5'd3, 5'd0, 5'd16, 5'd8, 5'd1, 5'd16};
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_wdata       <= '0;
		req_ch.valid    <= 1'b0;
		req_ch.action   <= sbmq_pkg::ACT_INSERT;
		req_ch.ident    <= '0;
		req_ch.payload  <= '0;
		req_ch.position <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue: read, remove and find out of range or missing; then first inserts
		send_request(sbmq_pkg::ACT_READ, 32'h0, 32'h0, 4'd0);
		send_request(sbmq_pkg::ACT_REMOVE, 32'h0, 32'h0, 4'd15);
		send_request(sbmq_pkg::ACT_FIND, 32'h0, 32'h0, 4'd0);
		send_request(sbmq_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
		send_request(sbmq_pkg::ACT_INSERT, 32'h0, 32'h0, 4'd0);
		send_request(sbmq_pkg::ACT_INSERT, 32'd5, 32'hA5A5_A5A5, 4'd0);
		// equal key goes after the existing one
		send_request(sbmq_pkg::ACT_INSERT, 32'd5, 32'h5A5A_5A5A, 4'd0);
		send_request(sbmq_pkg::ACT_FIND, 32'd5, 32'h0, 4'd0);
		send_request(sbmq_pkg::ACT_FIND, 32'd7, 32'h0, 4'd0);
		send_request(sbmq_pkg::ACT_READ, 32'h0, 32'h0, 4'd3);
		send_request(sbmq_pkg::ACT_READ, 32'h0, 32'h0, 4'd4);
		send_request(sbmq_pkg::ACT_REMOVE, 32'h0, 32'h0, 4'd1);
		send_request(sbmq_pkg::ACT_REMOVE, 32'h0, 32'h0, 4'd2);
		send_request(ACT_SPARE_0, 32'd5, 32'h0, 4'd0);
		send_request(ACT_SPARE_1, 32'd5, 32'h0, 4'd0);
		send_request(ACT_SPARE_2, 32'd5, 32'h0, 4'd0);
		send_request(sbmq_pkg::ACT_CLEAR, 32'h0, 32'h0, 4'd0);
		send_request(sbmq_pkg::ACT_READ, 32'h0, 32'h0, 4'd0);

		// single-entry queue: second insert replaces the first
		write_capacity(5'd1);
		send_request(sbmq_pkg::ACT_INSERT, 32'd9, 32'h1234_5678, 4'd0);
		send_request(sbmq_pkg::ACT_INSERT, 32'd3, 32'h8765_4321, 4'd0);
		send_request(sbmq_pkg::ACT_READ, 32'h0, 32'h0, 4'd0);

		for (int phase = 0; phase < 7; phase++) begin
			if (phase == 6)
				quiet = 1'b1;
			cap = (phase == 4) ? 5'($urandom_range(2, 15)) : caps[phase];
			write_capacity(cap);
			repeat (64) random_request();
		end
		req_ch.valid <= 1'b0;

		drain();
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

// ----- sim.f -----
rtl/core/sbmq_pkg.sv
rtl/core/sbmq_if.sv
rtl/core/sorted_bounded_message_queue_unit.sv
sim/tb_top.sv
